>>> rtl/core/c6xnpc_pkg.sv
// Shared types and constants for the C6x next-PC branch decoder.
package c6xnpc_pkg;

    localparam int REGS_PER_SIDE = 32;
    localparam int SIDE_SLOTS    = 32;
    localparam int REG_NUM_W     = $clog2(SIDE_SLOTS);
    localparam int REG_ADDR_W    = REG_NUM_W + 1;
    localparam int REG_COUNT     = 2 * SIDE_SLOTS;
    localparam int WORD_W        = 32;

    typedef enum logic [1:0] {
        CMD_WRITE_REG = 2'd0,
        CMD_START     = 2'd1,
        CMD_WORD      = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        OUT_NONE      = 2'd0,
        OUT_TAKEN     = 2'd1,
        OUT_NOT_TAKEN = 2'd2
    } outcome_t;

endpackage

>>> rtl/core/c6xnpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module c6xnpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/c6x_next_pc_branch_decoder.sv
// Top level of the C6x next-PC branch decoder.
// Requests on the slave side carry a command in s_tuser: write a register of the
// 64-entry mirror, start a search at an address, or feed the next instruction word.
// Each word is read at the running address; a true-predicated B, CALLP, BDEC, BNOP
// or BPOS, or a word with a clear p-bit, ends the search with one result on the
// master side (next PC in m_tdata, outcome in m_tuser). One request is accepted
// every cycle while the output is not stalled. The register mirror RAM is read when a
// word is accepted, and decode and target add then go into the output register
// as the decode stage advances. Writes and starts give no result.
module c6x_next_pc_branch_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [5:0] reg_index, [37:6] value, [39:38] zero
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] next_pc
    output logic [1:0]  m_tuser    // [1:0] outcome
);

    localparam int NW = c6xnpc_pkg::REG_NUM_W;
    localparam int AW = c6xnpc_pkg::REG_ADDR_W;
    localparam int WW = c6xnpc_pkg::WORD_W;
    localparam logic [NW-1:0] PRED_REGS = NW'(3);

    localparam logic [2:0] CREG_B0 = 3'd1;
    localparam logic [2:0] CREG_B1 = 3'd2;
    localparam logic [2:0] CREG_B2 = 3'd3;
    localparam logic [2:0] CREG_A1 = 3'd4;
    localparam logic [2:0] CREG_A2 = 3'd5;
    localparam logic [2:0] CREG_A0 = 3'd6;

    typedef enum logic [2:0] {
        FORM_NONE,
        FORM_BDISP,
        FORM_BREG,
        FORM_BDEC,
        FORM_BNOP,
        FORM_BNOPREG,
        FORM_BPOS
    } form_t;

    function automatic form_t decode_form(input logic [WW-1:0] w);
        form_t f;
        f = FORM_NONE;
        if ((w & 32'h0000_007c) == 32'h0000_0010) begin
            f = FORM_BDISP;
        end else if ((w & 32'h0f83_effc) == 32'h0000_0360) begin
            f = FORM_BREG;
        end else if ((w & 32'h0000_1ffc) == 32'h0000_1020) begin
            f = FORM_BDEC;
        end else if ((w & 32'h0000_1ffc) == 32'h0000_0120) begin
            f = FORM_BNOP;
        end else if ((w & 32'h0f83_0ffe) == 32'h0080_0362) begin
            f = FORM_BNOPREG;
        end else if ((w & 32'h0000_1ffc) == 32'h0000_0020) begin
            f = FORM_BPOS;
        end
        return f;
    endfunction

    // input side
    c6xnpc_pkg::cmd_t in_cmd;
    logic [AW-1:0]    in_idx;
    logic [WW-1:0]    in_val;
    logic             s_accept;
    logic             in_num_ok;
    logic             wr_en;
    logic             rd_en;
    form_t            in_form;
    logic [AW-1:0]    rd_addr;
    logic             rd_num_ok;
    logic             in_pred;
    logic             pred_nz;

    logic [c6xnpc_pkg::REG_COUNT-1:0] valid_reg;
    logic [2:0]                       nz_a_reg;
    logic [2:0]                       nz_b_reg;

    // decode stage
    logic             s1_valid_reg;
    c6xnpc_pkg::cmd_t s1_cmd_reg;
    logic [WW-1:0]    s1_word_reg;
    logic             s1_pred_reg;
    logic             s1_rd_ok_reg;
    logic [WW-1:0]    rd_data;
    logic             adv;

    logic [WW-1:0]    pc_reg;
    logic [WW-1:0]    pc_next;
    logic             searching_reg;
    logic             searching_next;

    form_t               s1_form;
    logic [WW-1:0]       base;
    logic [WW-1:0]       reg_val;
    logic [WW-1:0]       pc_plus4;
    logic                res_valid;
    logic [WW-1:0]       res_pc;
    c6xnpc_pkg::outcome_t res_out;
    logic                done;

    // output register
    logic                 m_valid_reg;
    logic [WW-1:0]        m_pc_reg;
    c6xnpc_pkg::outcome_t m_out_reg;

    assign in_cmd    = c6xnpc_pkg::cmd_t'(s_tuser);
    assign in_idx    = s_tdata[AW-1:0];
    assign in_val    = s_tdata[AW+WW-1:AW];
    assign s_accept  = s_tvalid && s_tready;
    assign in_num_ok = {1'b0, in_idx[NW-1:0]} < (NW+1)'(c6xnpc_pkg::REGS_PER_SIDE);
    assign wr_en     = s_accept && (in_cmd == c6xnpc_pkg::CMD_WRITE_REG) && in_num_ok;
    assign rd_en     = s_accept && (in_cmd == c6xnpc_pkg::CMD_WORD);
    assign in_form   = decode_form(in_val);

    always_comb begin
        case (in_form)
            FORM_BREG:    rd_addr = {in_val[1] ^ in_val[12], in_val[22:18]};
            FORM_BNOPREG: rd_addr = {~in_val[12], in_val[22:18]};
            default:      rd_addr = {in_val[1], in_val[27:23]};
        endcase
    end

    assign rd_num_ok = {1'b0, rd_addr[NW-1:0]} < (NW+1)'(c6xnpc_pkg::REGS_PER_SIDE);

    always_comb begin
        case (in_val[31:29])
            CREG_B0: pred_nz = nz_b_reg[0];
            CREG_B1: pred_nz = nz_b_reg[1];
            CREG_B2: pred_nz = nz_b_reg[2];
            CREG_A1: pred_nz = nz_a_reg[1];
            CREG_A2: pred_nz = nz_a_reg[2];
            CREG_A0: pred_nz = nz_a_reg[0];
            default: pred_nz = 1'b1;
        endcase
        if (in_val[31:29] == 3'd0 || in_val[31:29] == 3'd7) begin
            in_pred = 1'b1;
        end else begin
            in_pred = pred_nz ^ in_val[28];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            nz_a_reg  <= '0;
            nz_b_reg  <= '0;
        end else if (wr_en) begin
            valid_reg[in_idx] <= 1'b1;
            if (in_idx[NW-1:0] < PRED_REGS) begin
                if (in_idx[AW-1]) begin
                    nz_b_reg[in_idx[1:0]] <= (in_val != '0);
                end else begin
                    nz_a_reg[in_idx[1:0]] <= (in_val != '0);
                end
            end
        end
    end

    c6xnpc_ram #(
        .WIDTH (WW),
        .DEPTH (c6xnpc_pkg::REG_COUNT)
    ) u_regs (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (in_idx),
        .wr_data (in_val),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign adv      = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg   <= in_cmd;
            s1_word_reg  <= in_val;
            s1_pred_reg  <= in_pred;
            s1_rd_ok_reg <= valid_reg[rd_addr] && rd_num_ok;
        end
    end

    assign s1_form  = decode_form(s1_word_reg);
    assign base     = {pc_reg[WW-1:5], 5'b0};
    assign reg_val  = s1_rd_ok_reg ? rd_data : '0;
    assign pc_plus4 = pc_reg + WW'(4);

    always_comb begin
        pc_next        = pc_reg;
        searching_next = searching_reg;
        res_valid      = 1'b0;
        res_pc         = pc_plus4;
        res_out        = c6xnpc_pkg::OUT_NONE;
        done           = 1'b0;
        case (s1_cmd_reg)
            c6xnpc_pkg::CMD_START: begin
                pc_next        = s1_word_reg;
                searching_next = 1'b1;
            end
            c6xnpc_pkg::CMD_WORD: begin
                if (searching_reg) begin
                    if (s1_pred_reg) begin
                        done    = 1'b1;
                        res_out = c6xnpc_pkg::OUT_TAKEN;
                        case (s1_form)
                            FORM_BDISP: begin
                                res_pc = base + {{9{s1_word_reg[27]}},
                                                 s1_word_reg[27:7], 2'b00};
                            end
                            FORM_BREG, FORM_BNOPREG: begin
                                res_pc = reg_val;
                            end
                            FORM_BDEC: begin
                                res_pc = base + {{20{s1_word_reg[16]}},
                                                 s1_word_reg[16:7], 2'b00};
                            end
                            FORM_BNOP: begin
                                res_pc = base + {{18{s1_word_reg[27]}},
                                                 s1_word_reg[27:16], 2'b00};
                            end
                            FORM_BPOS: begin
                                res_pc = base + {{20{s1_word_reg[22]}},
                                                 s1_word_reg[22:13], 2'b00};
                            end
                            default: begin
                                done = 1'b0;
                            end
                        endcase
                        if ((s1_form == FORM_BDEC || s1_form == FORM_BPOS) && reg_val[WW-1]) begin
                            res_pc  = pc_reg;
                            res_out = c6xnpc_pkg::OUT_NOT_TAKEN;
                        end
                    end
                    if (done) begin
                        res_valid      = 1'b1;
                        searching_next = 1'b0;
                    end else begin
                        pc_next = pc_plus4;
                        res_pc  = pc_plus4;
                        res_out = c6xnpc_pkg::OUT_NONE;
                        if (!s1_word_reg[0]) begin
                            res_valid      = 1'b1;
                            searching_next = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= '0;
            searching_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (adv) begin
                pc_reg        <= pc_next;
                searching_reg <= searching_next;
                m_valid_reg   <= res_valid;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && res_valid) begin
            m_pc_reg  <= res_pc;
            m_out_reg <= res_out;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pc_reg;
    assign m_tuser  = m_out_reg;

endmodule

>>> rtl/core/c6xnpc_checker.sv
// Port-level assertions for the C6x next-PC branch decoder, bound to the top level.
module c6xnpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_outcome_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == c6xnpc_pkg::OUT_NONE || m_tuser == c6xnpc_pkg::OUT_TAKEN ||
                      m_tuser == c6xnpc_pkg::OUT_NOT_TAKEN))
        else $error("illegal outcome code");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request stalled with empty output");

endmodule

bind c6x_next_pc_branch_decoder c6xnpc_checker u_checker (.*);

>>> sim/tb_c6x_next_pc_branch_decoder.sv
// Self-checking testbench for the C6x next-PC branch decoder stream block.
module tb_c6x_next_pc_branch_decoder;
    import c6xnpc_pkg::*;

    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [31:0] PACKET_MASK = 32'hffff_ffe0;
    localparam logic [31:0] BDISP_MASK  = 32'h0000_007c;
    localparam logic [31:0] BDISP_PAT   = 32'h0000_0010;
    localparam logic [31:0] BREG_MASK   = 32'h0f83_effc;
    localparam logic [31:0] BREG_PAT    = 32'h0000_0360;
    localparam logic [31:0] BDEC_MASK   = 32'h0000_1ffc;
    localparam logic [31:0] BDEC_PAT    = 32'h0000_1020;
    localparam logic [31:0] BNOP_MASK   = 32'h0000_1ffc;
    localparam logic [31:0] BNOP_PAT    = 32'h0000_0120;
    localparam logic [31:0] BNOPR_MASK  = 32'h0f83_0ffe;
    localparam logic [31:0] BNOPR_PAT   = 32'h0080_0362;
    localparam logic [31:0] BPOS_MASK   = 32'h0000_1ffc;
    localparam logic [31:0] BPOS_PAT    = 32'h0000_0020;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          WORK_ITEMS  = 450;
    localparam int          LONG_HOLD   = 250;

    typedef enum int {
        F_PLAIN, F_END, F_BDISP, F_BREG, F_BDEC, F_BNOP, F_BNOPR, F_BPOS
    } word_form_t;

    typedef struct {
        logic [31:0] pc;
        outcome_t    oc;
    } npc_result_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [5:0]  idx;
        logic [31:0] val;
        bit          typed;
        logic [31:0] pc;
        outcome_t    oc;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    logic [31:0] gpr_mirror [REG_COUNT];
    logic [31:0] fetch_addr;
    bit          in_packet;

    npc_result_t next_pc_q [$];
    stim_row_t   directed_rows [$];

    int cycle_cnt;
    int err_cnt;
    int sent_cnt;
    int work_cnt;
    int result_cnt;
    int taken_cnt;
    int stop_cnt;
    int fall_cnt;

    c6x_next_pc_branch_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic logic [31:0] read_gpr(input logic side, input logic [4:0] num);
        if (int'(num) >= REGS_PER_SIDE) return 32'h0;
        return gpr_mirror[int'(side) * SIDE_SLOTS + int'(num)];
    endfunction

    function automatic bit predict_next_pc(input logic [1:0] cmd, input logic [5:0] idx,
                                           input logic [31:0] w,
                                           output logic [31:0] npc, output outcome_t oc);
        logic [31:0] v;
        logic [31:0] base;
        bit          pred;
        bit          done;
        npc  = 32'h0;
        oc   = OUT_NONE;
        done = 1'b0;
        if (cmd == CMD_WRITE_REG) begin
            if (int'(idx[4:0]) < REGS_PER_SIDE) gpr_mirror[idx] = w;
            return 1'b0;
        end
        if (cmd == CMD_START) begin
            fetch_addr = w;
            in_packet  = 1'b1;
            return 1'b0;
        end
        if (cmd != CMD_WORD || !in_packet) return 1'b0;

        pred = 1'b1;
        v    = 32'h0;
        case (w[31:29])
            3'd1: v = read_gpr(1'b1, 5'd0);
            3'd2: v = read_gpr(1'b1, 5'd1);
            3'd3: v = read_gpr(1'b1, 5'd2);
            3'd4: v = read_gpr(1'b0, 5'd1);
            3'd5: v = read_gpr(1'b0, 5'd2);
            3'd6: v = read_gpr(1'b0, 5'd0);
            default: v = 32'h0;
        endcase
        if (w[31:29] != 3'd0 && w[31:29] != 3'd7) pred = w[28] ? (v == 0) : (v != 0);

        base = fetch_addr & PACKET_MASK;
        if (pred) begin
            if ((w & BDISP_MASK) == BDISP_PAT) begin
                npc  = base + {{9{w[27]}}, w[27:7], 2'b00};
                oc   = OUT_TAKEN;
                done = 1'b1;
            end else if ((w & BREG_MASK) == BREG_PAT) begin
                npc  = read_gpr(w[1] ^ w[12], w[22:18]);
                oc   = OUT_TAKEN;
                done = 1'b1;
            end else if ((w & BDEC_MASK) == BDEC_PAT) begin
                v = read_gpr(w[1], w[27:23]);
                if (!v[31]) begin
                    npc = base + {{20{w[16]}}, w[16:7], 2'b00};
                    oc  = OUT_TAKEN;
                end else begin
                    npc = fetch_addr;
                    oc  = OUT_NOT_TAKEN;
                end
                done = 1'b1;
            end else if ((w & BNOP_MASK) == BNOP_PAT) begin
                npc  = base + {{18{w[27]}}, w[27:16], 2'b00};
                oc   = OUT_TAKEN;
                done = 1'b1;
            end else if ((w & BNOPR_MASK) == BNOPR_PAT) begin
                npc  = read_gpr(1'b1 ^ w[12], w[22:18]);
                oc   = OUT_TAKEN;
                done = 1'b1;
            end else if ((w & BPOS_MASK) == BPOS_PAT) begin
                v = read_gpr(w[1], w[27:23]);
                if (!v[31]) begin
                    npc = base + {{20{w[22]}}, w[22:13], 2'b00};
                    oc  = OUT_TAKEN;
                end else begin
                    npc = fetch_addr;
                    oc  = OUT_NOT_TAKEN;
                end
                done = 1'b1;
            end
        end

        if (!done) begin
            fetch_addr = fetch_addr + 32'd4;
            if (w[0]) return 1'b0;
            npc = fetch_addr;
            oc  = OUT_NONE;
        end
        in_packet = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] make_word(input word_form_t form);
        logic [31:0] r;
        logic [31:0] mask;
        logic [31:0] pat;
        logic [2:0]  creg;
        logic [31:0] w;
        r    = $urandom;
        creg = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
        w    = {creg, r[28:0]};
        mask = 32'h0;
        pat  = 32'h0;
        case (form)
            F_PLAIN: w[0] = 1'b1;
            F_END:   w[0] = 1'b0;
            F_BDISP: begin mask = BDISP_MASK; pat = BDISP_PAT; end
            F_BREG:  begin mask = BREG_MASK;  pat = BREG_PAT;  end
            F_BDEC:  begin mask = BDEC_MASK;  pat = BDEC_PAT;  end
            F_BNOP:  begin mask = BNOP_MASK;  pat = BNOP_PAT;  end
            F_BNOPR: begin mask = BNOPR_MASK; pat = BNOPR_PAT; end
            default: begin mask = BPOS_MASK;  pat = BPOS_PAT;  end
        endcase
        return (w & ~mask) | pat;
    endfunction

    function automatic logic [31:0] pick_reg_value();
        case ($urandom_range(0, 4))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'h8000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(input logic [1:0] cmd, input logic [5:0] idx, input logic [31:0] val,
                           input bit typed, input logic [31:0] pc, input outcome_t oc);
        stim_row_t r;
        r.cmd = cmd; r.idx = idx; r.val = val; r.typed = typed; r.pc = pc; r.oc = oc;
        directed_rows.push_back(r);
    endtask

    task automatic report_error(input string what, input logic [31:0] epc, input logic [1:0] eoc);
        err_cnt++;
        if (err_cnt <= 10)
            $display("ERROR %s: expected pc=%08h outcome=%0d, got pc=%08h outcome=%0d",
                     what, epc, eoc, m_tdata, m_tuser);
    endtask

    task automatic send_req(input logic [1:0] cmd, input logic [5:0] idx, input logic [31:0] val,
                            input bit typed, input logic [31:0] tpc, input outcome_t toc);
        int          gap;
        bit          has;
        bit          counts;
        logic [31:0] npc;
        outcome_t    noc;
        npc_result_t e;
        gap = (sent_cnt % 120 < 40) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, val, idx};
        do @(posedge aclk); while (!s_tready);
        counts = !(cmd == CMD_UNUSED || (cmd == CMD_WORD && !in_packet));
        has    = predict_next_pc(cmd, idx, val, npc, noc);
        if (typed) begin
            e.pc = tpc; e.oc = toc;
            next_pc_q.push_back(e);
        end else if (has) begin
            e.pc = npc; e.oc = noc;
            next_pc_q.push_back(e);
        end
        sent_cnt++;
        if (counts) work_cnt++;
    endtask

    task automatic random_write();
        logic [5:0] idx;
        case ($urandom_range(0, 7))
            0: idx = 6'd0;
            1: idx = 6'd1;
            2: idx = 6'd2;
            3: idx = 6'd32;
            4: idx = 6'd33;
            5: idx = 6'd34;
            default: idx = 6'($urandom_range(0, 63));
        endcase
        send_req(CMD_WRITE_REG, idx, pick_reg_value(), 1'b0, 32'h0, OUT_NONE);
    endtask

    task automatic random_packet();
        int n;
        repeat ($urandom_range(0, 2)) random_write();
        send_req(CMD_START, 6'($urandom), $urandom, 1'b0, 32'h0, OUT_NONE);
        n = $urandom_range(0, 4);
        repeat (n) begin
            if ($urandom_range(0, 5) == 0) random_write();
            send_req(CMD_WORD, 6'($urandom), make_word(F_PLAIN), 1'b0, 32'h0, OUT_NONE);
        end
        send_req(CMD_WORD, 6'($urandom), make_word(word_form_t'($urandom_range(1, 7))),
                 1'b0, 32'h0, OUT_NONE);
    endtask

    task automatic random_noise();
        case ($urandom_range(0, 3))
            0: send_req(CMD_UNUSED, 6'($urandom), $urandom, 1'b0, 32'h0, OUT_NONE);
            1: send_req(CMD_WORD, 6'($urandom), $urandom, 1'b0, 32'h0, OUT_NONE);
            2: random_write();
            default: begin
                send_req(CMD_START, 6'($urandom), $urandom, 1'b0, 32'h0, OUT_NONE);
                repeat ($urandom_range(0, 2))
                    send_req(CMD_WORD, 6'($urandom), make_word(F_PLAIN), 1'b0, 32'h0, OUT_NONE);
            end
        endcase
    endtask

    // receive side: random stalls, one long hold to back up the block
    initial begin
        int          stall;
        bit          held;
        npc_result_t e;
        held     = 1'b0;
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = ((result_cnt / 15) % 3 == 1) ? 0 : $urandom_range(0, 13);
            if (!held && result_cnt == 40) begin
                stall = LONG_HOLD;
                held  = 1'b1;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            result_cnt++;
            if (next_pc_q.size() == 0) begin
                report_error("unexpected result", 32'h0, 2'd0);
            end else begin
                e = next_pc_q.pop_front();
                if (m_tdata !== e.pc || m_tuser !== e.oc) report_error("mismatch", e.pc, e.oc);
                case (e.oc)
                    OUT_TAKEN:     taken_cnt++;
                    OUT_NOT_TAKEN: stop_cnt++;
                    default:       fall_cnt++;
                endcase
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles", cycle_cnt);
        $display("tb_c6x_next_pc_branch_decoder: FAIL");
        $finish;
    end

    initial begin
        bit paused;
        paused    = 1'b0;
        cycle_cnt = 0;
        err_cnt   = 0;
        sent_cnt  = 0;
        work_cnt  = 0;
        result_cnt = 0;
        taken_cnt = 0;
        stop_cnt  = 0;
        fall_cnt  = 0;
        in_packet = 1'b0;
        fetch_addr = 32'h0;
        foreach (gpr_mirror[i]) gpr_mirror[i] = 32'h0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;

        add_row(CMD_WORD,      6'd0,  32'h0000_0000, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_UNUSED,    6'd63, 32'hffff_ffff, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_START,     6'd0,  32'h0000_0000, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_WORD,      6'd0,  32'h0000_0000, 1'b1, 32'h0000_0004, OUT_NONE);
        add_row(CMD_START,     6'd0,  32'hffff_fffc, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_WORD,      6'd0,  32'h0800_0010, 1'b1, 32'hffbf_ffe0, OUT_TAKEN);
        add_row(CMD_START,     6'd0,  32'h0000_001f, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_WORD,      6'd0,  32'h07ff_ff90, 1'b1, 32'h003f_fffc, OUT_TAKEN);
        add_row(CMD_WRITE_REG, 6'd32, 32'h0000_0001, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_WRITE_REG, 6'd63, 32'hffff_ffff, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_WRITE_REG, 6'd1,  32'h8000_0000, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_START,     6'd0,  32'h0000_1000, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_WORD,      6'd0,  32'h2000_0001, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_WORD,      6'd0,  32'h3000_0010, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_START,     6'd0,  32'h0000_2004, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_WORD,      6'd0,  32'h007c_0362, 1'b1, 32'hffff_ffff, OUT_TAKEN);
        add_row(CMD_START,     6'd0,  32'h0000_3000, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_WORD,      6'd0,  32'h0080_1020, 1'b1, 32'h0000_3000, OUT_NOT_TAKEN);
        add_row(CMD_START,     6'd0,  32'h0000_3000, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_WORD,      6'd0,  32'h0001_1022, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_START,     6'd0,  32'h0000_0040, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_WORD,      6'd0,  32'h07ff_0120, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_START,     6'd0,  32'h0000_0000, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_WORD,      6'd0,  32'h00fc_0362, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_START,     6'd0,  32'h0000_0100, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_WORD,      6'd0,  32'h003f_e022, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_START,     6'd0,  32'h0000_0500, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_START,     6'd0,  32'hffff_fffc, 1'b0, 32'h0, OUT_NONE);
        add_row(CMD_WORD,      6'd0,  32'he000_0000, 1'b1, 32'h0000_0000, OUT_NONE);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_req(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].val,
                     directed_rows[i].typed, directed_rows[i].pc, directed_rows[i].oc);

        while (work_cnt < WORK_ITEMS) begin
            if (!paused && work_cnt >= 300) begin
                // hold the sender until the result queue drains
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (next_pc_q.size() != 0);
                paused = 1'b1;
            end
            if ($urandom_range(0, 3) != 0) random_packet();
            else random_noise();
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (next_pc_q.size() != 0);
        repeat (8) @(posedge aclk);

        if (next_pc_q.size() != 0) begin
            err_cnt += next_pc_q.size();
            $display("ERROR %0d results never arrived", next_pc_q.size());
        end
        $display("covered %0d requests (%0d effective), %0d results in %0d cycles",
                 sent_cnt, work_cnt, result_cnt, cycle_cnt);
        $display("outcomes: %0d taken, %0d not-taken stops, %0d fall-through; %0d errors",
                 taken_cnt, stop_cnt, fall_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("tb_c6x_next_pc_branch_decoder: PASS");
        end else begin
            $display("tb_c6x_next_pc_branch_decoder: FAIL");
        end
        $finish;
    end

endmodule
